@@ hw/rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg: shared constants and types
// Widths, status codes and the compare unit's request and response
// structures used by the free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int POOL_UNITS = 4096;
  localparam int ADDR_W     = $clog2(POOL_UNITS);
  localparam int SIZE_W     = 13;
  localparam int STEP_W     = $clog2(POOL_UNITS + 1);
  localparam int NODE_W     = SIZE_W + ADDR_W;

  localparam logic [2:0] ST_REUSED    = 3'd0;
  localparam logic [2:0] ST_BUMP      = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  // The compare unit tests a >= b + c and hands back the sum b + c.
  typedef struct packed {
    logic [SIZE_W-1:0] a;
    logic [SIZE_W-1:0] b;
    logic [SIZE_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic              ge;
    logic [SIZE_W-1:0] sum;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffa_ram.sv @@
// ----------------------------------------------------------------------------
// ffa_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ffa_alu.sv @@
// ----------------------------------------------------------------------------
// ffa_alu: shared add and compare unit
// Computes b + c without overflow and tests whether a reaches that sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffa_alu (
  input  wire ffa_pkg::alu_req_t req,
  output ffa_pkg::alu_rsp_t      rsp
);

  logic [ffa_pkg::SIZE_W:0] wide_sum;

  assign wide_sum = {1'b0, req.b} + {1'b0, req.c};
  assign rsp.ge   = {1'b0, req.a} >= wide_sum;
  assign rsp.sum  = wide_sum[ffa_pkg::SIZE_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator: first-fit pool allocator with a free list
// A free pushes a block onto the head of a singly linked list kept in one
// node RAM; an allocate walks that list for the first block that fits and
// falls back to bump allocation below the pool limit.
// ----------------------------------------------------------------------------
// Sequence: a free answers the cycle after acceptance; an allocate answers
//   from LOOK when it reuses a listed node, else after the walk from BUMP_A
//   when the bump pointer is already at the limit, or from BUMP_B.
// Throughput: one item at a time, one node per cycle in the walk (one RAM
//   read port); a new item is taken the cycle after the result beat leaves.
// Reset: empty list, bump pointer 1, limit 4096; the node RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_free_list_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Command channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          command,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    block_units,
  input  wire logic [ffa_pkg::ADDR_W-1:0]    free_offset,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [2:0]                    status,
  output logic      [ffa_pkg::ADDR_W-1:0]    block_offset,
  // Configuration channel for the pool limit.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ffa_pkg::SIZE_W-1:0]    pool_limit
);

  // Sequencer states. IDLE takes a command and finishes a free in place.
  // LOOK checks the node whose entry the RAM returns this cycle and, on a
  // miss, already addresses the next node. BUMP_A tests that the bump
  // pointer lies below the limit, BUMP_B that the request fits under it.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOK   = 2'd1;
  localparam logic [1:0] S_BUMP_A = 2'd2;
  localparam logic [1:0] S_BUMP_B = 2'd3;

  localparam logic [ffa_pkg::SIZE_W-1:0] POOL_MAX = ffa_pkg::SIZE_W'(ffa_pkg::POOL_UNITS);
  localparam logic [ffa_pkg::STEP_W-1:0] STEP_MAX = ffa_pkg::STEP_W'(ffa_pkg::POOL_UNITS);
  localparam logic [ffa_pkg::SIZE_W-1:0] ONE      = ffa_pkg::SIZE_W'(1);
  localparam logic [ffa_pkg::SIZE_W-1:0] ZERO     = '0;

  logic [1:0]                   state;
  logic [ffa_pkg::ADDR_W-1:0]   list_head;
  logic [ffa_pkg::SIZE_W-1:0]   bump_pointer;
  logic [ffa_pkg::SIZE_W-1:0]   limit;
  logic [ffa_pkg::SIZE_W-1:0]   units;
  logic [ffa_pkg::ADDR_W-1:0]   cur;
  logic [ffa_pkg::ADDR_W-1:0]   prev;
  logic [ffa_pkg::SIZE_W-1:0]   prev_size;
  logic                         prev_valid;
  logic [ffa_pkg::STEP_W-1:0]   steps;

  logic                         in_beat;
  logic                         out_free;
  logic [ffa_pkg::STEP_W-1:0]   steps_next;

  ffa_pkg::alu_req_t            alu_req;
  ffa_pkg::alu_rsp_t            alu_rsp;

  logic                         ram_we;
  logic [ffa_pkg::ADDR_W-1:0]   ram_waddr;
  logic [ffa_pkg::NODE_W-1:0]   ram_wdata;
  logic [ffa_pkg::ADDR_W-1:0]   ram_raddr;
  logic [ffa_pkg::NODE_W-1:0]   ram_rdata;
  logic [ffa_pkg::SIZE_W-1:0]   node_size;
  logic [ffa_pkg::ADDR_W-1:0]   node_next;

  // Each RAM word holds a node's size above its next pointer.
  assign node_size = ram_rdata[ffa_pkg::NODE_W-1:ffa_pkg::ADDR_W];
  assign node_next = ram_rdata[ffa_pkg::ADDR_W-1:0];

  // The output register is free only when it is empty. A new command
  // waits for an empty register, so every command has room for its single
  // result beat.
  assign out_free   = !out_valid;
  assign in_stall   = (state != S_IDLE) || !out_free;
  assign in_beat    = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign steps_next = steps + 1'b1;

  // The single compare unit is pointed at different operands by state:
  // free offset against the limit, node size against the request, and the
  // two bump tests.
  always_comb begin
    alu_req.a = limit;
    alu_req.b = ZERO;
    alu_req.c = ZERO;
    case (state)
      S_IDLE: begin
        alu_req.b = {1'b0, free_offset};
        alu_req.c = ONE;
      end
      S_LOOK: begin
        alu_req.a = node_size;
        alu_req.b = units;
      end
      S_BUMP_A: begin
        alu_req.b = bump_pointer;
        alu_req.c = ONE;
      end
      S_BUMP_B: begin
        alu_req.b = bump_pointer;
        alu_req.c = units;
      end
      default: begin
        alu_req.a = limit;
      end
    endcase
  end

  ffa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // RAM port control. In IDLE the read is aimed at the list head so that
  // an allocate finds the first node's entry waiting in LOOK; in LOOK it
  // follows the next pointer of the node being checked. Writes come from
  // an accepted free (push a new head) and from unlinking a reused node
  // behind a predecessor.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = prev;
    ram_wdata = {prev_size, node_next};
    ram_raddr = list_head;
    case (state)
      S_IDLE: begin
        ram_waddr = free_offset;
        ram_wdata = {block_units, list_head};
        ram_we    = in_beat && command && alu_rsp.ge && (free_offset != '0);
      end
      S_LOOK: begin
        ram_raddr = node_next;
        ram_we    = alu_rsp.ge && prev_valid;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffa_ram #(
    .WIDTH (ffa_pkg::NODE_W),
    .DEPTH (ffa_pkg::POOL_UNITS)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      list_head    <= '0;
      bump_pointer <= ONE;
      limit        <= POOL_MAX;
      prev_valid   <= 1'b0;
      steps        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // The limit in force never exceeds the pool itself.
      if (cfg_valid && cfg_ready) begin
        limit <= (pool_limit > POOL_MAX) ? POOL_MAX : pool_limit;
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            units      <= block_units;
            cur        <= list_head;
            prev_valid <= 1'b0;
            steps      <= '0;
            if (command) begin
              // A free finishes here: offset zero is the header, and an
              // offset at or past the limit lies outside the pool.
              out_valid    <= 1'b1;
              block_offset <= '0;
              if (alu_rsp.ge && (free_offset != '0)) begin
                list_head <= free_offset;
                status    <= ffa_pkg::ST_FREED;
              end else begin
                status <= ffa_pkg::ST_REJECTED;
              end
            end else if (list_head == '0) begin
              state <= S_BUMP_A;
            end else begin
              state <= S_LOOK;
            end
          end
        end

        S_LOOK: begin
          if (alu_rsp.ge) begin
            // First fit: take the whole node and splice it out.
            if (!prev_valid) begin
              list_head <= node_next;
            end
            out_valid    <= 1'b1;
            status       <= ffa_pkg::ST_REUSED;
            block_offset <= cur;
            state        <= S_IDLE;
          end else begin
            prev       <= cur;
            prev_size  <= node_size;
            prev_valid <= 1'b1;
            cur        <= node_next;
            steps      <= steps_next;
            // The walk ends at the list's end, or after as many nodes as
            // the pool holds, which bounds a list that loops on itself.
            if ((node_next == '0) || (steps_next == STEP_MAX)) begin
              state <= S_BUMP_A;
            end
          end
        end

        S_BUMP_A: begin
          if (alu_rsp.ge) begin
            state <= S_BUMP_B;
          end else begin
            out_valid    <= 1'b1;
            status       <= ffa_pkg::ST_EXHAUSTED;
            block_offset <= '0;
            state        <= S_IDLE;
          end
        end

        S_BUMP_B: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
          if (alu_rsp.ge) begin
            status       <= ffa_pkg::ST_BUMP;
            block_offset <= bump_pointer[ffa_pkg::ADDR_W-1:0];
            bump_pointer <= alu_rsp.sum;
          end else begin
            status       <= ffa_pkg::ST_EXHAUSTED;
            block_offset <= '0;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/first_fit_free_list_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_test: self-checking bench for the allocator
// Drives allocate and free commands through the stall handshake and keeps a
// behavioral copy of the free list, bump pointer and pool limit. Every
// result beat is compared field by field with the predicted reply. The run
// covers directed corner cases, several limit settings, random traffic and
// a closing double free.
// ----------------------------------------------------------------------------

module first_fit_free_list_allocator_test;

  // A run of this many cycles with no beat on any channel is a hang. The
  // slowest legal item is a walk around a cyclic list of POOL_UNITS nodes.
  localparam int STALL_LIMIT = 20000;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef logic [ffa_pkg::SIZE_W-1:0] units_t;
  typedef logic [ffa_pkg::ADDR_W-1:0] offset_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic [ffa_pkg::ADDR_W-1:0] offset;
  } reply_t;

  // A block that the bench holds and may hand back later.
  typedef struct packed {
    logic [ffa_pkg::ADDR_W-1:0] offset;
    logic [ffa_pkg::SIZE_W-1:0] units;
  } held_t;

  // Behavioral copy of the allocator plus the queue of replies still owed.
  class pool_ledger;
    logic [ffa_pkg::SIZE_W-1:0] limit_reg;
    logic [ffa_pkg::ADDR_W-1:0] head;
    logic [ffa_pkg::SIZE_W-1:0] bump;
    logic [ffa_pkg::SIZE_W-1:0] node_units [ffa_pkg::POOL_UNITS];
    logic [ffa_pkg::ADDR_W-1:0] node_link [ffa_pkg::POOL_UNITS];
    bit                         listed [ffa_pkg::POOL_UNITS];
    reply_t                     awaited [$];
    int                         errors;

    function new();
      limit_reg = 13'd4096;
      head      = '0;
      bump      = 13'd1;
      errors    = 0;
      foreach (listed[i]) listed[i] = 1'b0;
    endfunction

    function int limit_now();
      return (limit_reg < ffa_pkg::POOL_UNITS) ? int'(limit_reg) : ffa_pkg::POOL_UNITS;
    endfunction

    // Applies one accepted command to the copy and queues the reply it owes.
    function reply_t note_command(cmd_t cmd, logic [ffa_pkg::SIZE_W-1:0] units,
                                  logic [ffa_pkg::ADDR_W-1:0] off);
      reply_t                     r;
      logic [ffa_pkg::ADDR_W-1:0] cur;
      logic [ffa_pkg::ADDR_W-1:0] prev;
      bit                         have_prev;
      bit                         found;
      int                         steps;
      int                         lim;
      lim       = limit_now();
      r.status  = ffa_pkg::ST_EXHAUSTED;
      r.offset  = '0;
      cur       = head;
      prev      = '0;
      have_prev = 1'b0;
      found     = 1'b0;
      steps     = 0;
      if (cmd == CMD_ALLOC) begin
        // First fit; a cyclic list is cut off after POOL_UNITS nodes.
        while (cur != 0 && steps < ffa_pkg::POOL_UNITS && !found) begin
          if (node_units[cur] >= units) begin
            if (have_prev) begin
              node_link[prev] = node_link[cur];
            end else begin
              head = node_link[cur];
            end
            listed[cur] = 1'b0;
            found = 1'b1;
          end else begin
            prev      = cur;
            have_prev = 1'b1;
            cur       = node_link[cur];
            steps++;
          end
        end
        if (found) begin
          r.status = ffa_pkg::ST_REUSED;
          r.offset = cur;
        end else if (int'(bump) < lim && int'(bump) + int'(units) <= lim) begin
          r.status = ffa_pkg::ST_BUMP;
          r.offset = bump[ffa_pkg::ADDR_W-1:0];
          bump     = bump + units;
        end
      end else if (off == 0 || int'(off) >= lim) begin
        r.status = ffa_pkg::ST_REJECTED;
      end else begin
        node_units[off] = units;
        node_link[off]  = head;
        head            = off;
        listed[off]     = 1'b1;
        r.status        = ffa_pkg::ST_FREED;
      end
      awaited.push_back(r);
      return r;
    endfunction

    function void complain(string what, int want, int got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [2:0] st, logic [ffa_pkg::ADDR_W-1:0] off);
      reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, expected none, actual status %0d offset %0d",
                 $time, st, off);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) complain("status", int'(want.status), int'(st));
      if (off !== want.offset) complain("block_offset", int'(want.offset), int'(off));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic                       command;
  logic [ffa_pkg::SIZE_W-1:0] block_units;
  logic [ffa_pkg::ADDR_W-1:0] free_offset;
  logic                       out_valid;
  logic                       out_stall;
  logic [2:0]                 status;
  logic [ffa_pkg::ADDR_W-1:0] block_offset;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [ffa_pkg::SIZE_W-1:0] pool_limit;

  pool_ledger ledger = new();
  held_t      held_blocks [$];

  // While set, neither side inserts idle cycles or stalls.
  bit no_idle = 1'b0;
  int random_issued = 0;

  // Receiver bookkeeping for the one long hold-off.
  int replies_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  first_fit_free_list_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .block_units  (block_units),
    .free_offset  (free_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .block_offset (block_offset),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .pool_limit   (pool_limit)
  );

  // Result side. Everything is sampled at the rising edge, before the
  // block's own register updates land, and the stall for the next cycle is
  // driven with a single nonblocking assignment per edge. Once two hundred
  // beats have arrived, the receiver holds off for a long stretch so that
  // the output register fills and the block pushes back on its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        ledger.check_result(status, block_offset);
        replies_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && replies_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 18);
      end
    end
  end

  // Hang detector: counts consecutive cycles in which no beat moves on any
  // channel, and gives up once the count reaches the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Offers one command beat, optionally after a few idle cycles, and waits
  // for it to be taken. The payload only moves after acceptance. Valid is
  // left high so that a following beat can go out on the very next cycle.
  task automatic send_command(cmd_t cmd, logic [ffa_pkg::SIZE_W-1:0] units,
                              logic [ffa_pkg::ADDR_W-1:0] off);
    reply_t r;
    while (!no_idle && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    block_units <= units;
    free_offset <= off;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = ledger.note_command(cmd, units, off);
    // Blocks the block handed out become candidates for a later free.
    if (r.status == ffa_pkg::ST_REUSED || r.status == ffa_pkg::ST_BUMP)
      held_blocks.push_back('{r.offset, units});
  endtask

  // The limit only changes with the block idle: input stopped and every
  // owed reply received. Every command yields exactly one reply, so the
  // empty queue means that nothing is left in flight.
  task automatic set_limit(logic [ffa_pkg::SIZE_W-1:0] value);
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    cfg_valid  <= 1'b1;
    pool_limit <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ledger.limit_reg = value;
  endtask

  // Random traffic. Most of it is well formed: allocations of mostly small
  // sizes, and frees that hand back blocks the block gave out, so that the
  // list grows and gets reused. The rest is noise: frees at arbitrary
  // offsets and frees that must be rejected. A free of a node that is
  // still on the list is turned into an allocation, since that would close
  // the list into a loop for the rest of the run.
  task automatic run_random_phase(int count);
    cmd_t                       cmd;
    logic [ffa_pkg::SIZE_W-1:0] units;
    logic [ffa_pkg::ADDR_W-1:0] off;
    held_t                      blk;
    int                         pick;
    int                         k;
    int                         lim;
    repeat (count) begin
      no_idle = (random_issued >= 300 && random_issued < 420);
      lim  = ledger.limit_now();
      pick = $urandom_range(99);
      k    = $urandom_range(99);
      cmd  = CMD_ALLOC;
      off  = offset_t'($urandom());
      units = (k < 70) ? units_t'($urandom_range(0, 16)) :
              (k < 90) ? units_t'($urandom_range(0, 4096)) :
              (k < 95) ? 13'd4096 : 13'd0;
      if (pick >= 45 && pick < 80 && held_blocks.size() > 0) begin
        k   = $urandom_range(held_blocks.size() - 1);
        blk = held_blocks[k];
        held_blocks.delete(k);
        if (!ledger.listed[blk.offset]) begin
          cmd = CMD_FREE;
          off = blk.offset;
          // Now and then the size given back differs from the one taken.
          if ($urandom_range(9) != 0) units = blk.units;
        end
      end else if (pick >= 80 && pick < 90) begin
        off = offset_t'($urandom_range(1, ffa_pkg::POOL_UNITS - 1));
        if (!ledger.listed[off]) cmd = CMD_FREE;
      end else if (pick >= 90) begin
        cmd = CMD_FREE;
        off = (lim < ffa_pkg::POOL_UNITS && $urandom_range(1) == 1) ?
              offset_t'($urandom_range(lim, ffa_pkg::POOL_UNITS - 1)) : '0;
      end
      send_command(cmd, units, off);
      random_issued++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic [ffa_pkg::ADDR_W-1:0] twice_freed;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    command     <= CMD_ALLOC;
    block_units <= '0;
    free_offset <= '0;
    cfg_valid   <= 1'b0;
    pool_limit  <= 13'd4096;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // At the reset limit a zero-size request bumps at unit 1 and leaves the
    // bump pointer where it is.
    send_command(CMD_ALLOC, 13'd0, 12'd0);

    // Limit of one unit: only the header fits, so nothing can be handed out
    // and every free is out of the pool, offset zero included.
    set_limit(13'd1);
    send_command(CMD_ALLOC, 13'd0, 12'd0);
    send_command(CMD_FREE, 13'd1, 12'd1);
    send_command(CMD_FREE, 13'd4, 12'd0);

    // A sixteen-unit pool to walk the bump pointer right up to the limit.
    set_limit(13'd16);
    send_command(CMD_ALLOC, 13'd0, 12'd0);       // zero size, bumps at 1
    send_command(CMD_ALLOC, 13'd4096, 12'd0);    // largest request, no room
    send_command(CMD_ALLOC, 13'd5, 12'd0);       // bumps at 1
    send_command(CMD_ALLOC, 13'd10, 12'd0);      // bumps at 6, pool now full
    send_command(CMD_ALLOC, 13'd0, 12'd0);       // zero size with bump at limit
    send_command(CMD_FREE, 13'd10, 12'd6);
    send_command(CMD_FREE, 13'd5, 12'd1);
    send_command(CMD_FREE, 13'd3, 12'd4095);     // top offset, out of pool
    send_command(CMD_FREE, 13'd3, 12'd16);       // offset equal to the limit
    send_command(CMD_FREE, 13'd4096, 12'd15);
    send_command(CMD_ALLOC, 13'd7, 12'd4095);    // taken from the list head
    send_command(CMD_ALLOC, 13'd8, 12'd0);       // skips one node, unlinks tail
    send_command(CMD_ALLOC, 13'd6, 12'd0);       // no fit and no room
    send_command(CMD_ALLOC, 13'd5, 12'd0);       // exact fit empties the list
    send_command(CMD_FREE, 13'd0, 12'd3);
    send_command(CMD_ALLOC, 13'd0, 12'd0);       // zero-size node still fits
    send_command(CMD_FREE, 13'd2, 12'd9);        // an offset inside a live block

    // Limit dropped below the bump pointer: bumping always fails, while
    // the list keeps working for offsets under the new limit.
    set_limit(13'd4);
    send_command(CMD_FREE, 13'd1, 12'd3);
    send_command(CMD_FREE, 13'd1, 12'd4);
    send_command(CMD_ALLOC, 13'd3, 12'd0);
    send_command(CMD_ALLOC, 13'd2, 12'd0);       // unlinks behind the head

    set_limit(13'd4096);
    run_random_phase(180);
    set_limit(13'd2);
    run_random_phase(180);
    set_limit(13'd4095);
    run_random_phase(180);
    set_limit(units_t'($urandom_range(1, 4096)));
    run_random_phase(180);
    set_limit(13'd4096);
    run_random_phase(180);

    // Closing case: the same block freed twice links to itself. A request
    // it cannot satisfy then walks the loop until the step bound, and one
    // that fits keeps getting the same block. The loop never goes away,
    // so this comes last.
    set_limit(13'd4096);
    twice_freed = 12'd100;
    while (ledger.listed[twice_freed]) twice_freed++;
    send_command(CMD_FREE, 13'd3, twice_freed);
    send_command(CMD_FREE, 13'd3, twice_freed);
    send_command(CMD_ALLOC, 13'd4000, 12'd0);
    send_command(CMD_ALLOC, 13'd2, 12'd0);
    send_command(CMD_ALLOC, 13'd4095, 12'd0);

    // Drain, then give the block a short while to show any stray beat.
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.errors == 0 && ledger.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
